>>> sv/scs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the secant concentration search block.
// Depends on nothing; used by secant_concentration_search, scs_checker and the testbench.

package scs_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_WMUL,
        S_SMUL,
        S_DIV,
        S_UPDATE,
        S_CMUL,
        S_DONE
    } t_state;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_TARGET    = 3'd0;
    localparam logic [2:0] REG_TOLERANCE = 3'd1;
    localparam logic [2:0] REG_ABUNDANCE = 3'd2;
    localparam logic [2:0] REG_EPSILON   = 3'd3;
    localparam logic [2:0] REG_INIT_CONC = 3'd4;
    localparam logic [2:0] REG_CONFIDENCE = 3'd5;

    localparam int ADDR_W       = 5;
    localparam int CONF_FRAC    = 12;
    localparam int ABUND_FRAC   = 16;
    localparam int STEP_UNITS   = 1000;
    localparam int DIV_STEPS    = 64;

    localparam logic [29:0] TOL_RESET   = 30'd107374;
    localparam logic [16:0] ABUND_RESET = 17'd13042;
    localparam logic [15:0] CONF_RESET  = 16'd8028;

endpackage

>>> sv/secant_concentration_search.sv
`timescale 1ns / 1ps
// Secant search for the concentration that drives a measured factor to target.
// Depends on scs_pkg for the sequencer state type and register indexes.

// Usage:
// A request on the slave stream carries three factors in tdata and the
// first-pass flag in tuser. One result leaves on the master stream per request.
// The registers are written over the APB port while the block is idle;
// writing the initial concentration also loads both stored concentrations.
// A secant request uses the single shared 32x32 multiplier three times (interval
// width, secant product, scaled change) around the one-bit-per-cycle restoring
// divider. A first-pass request or one with equal factors skips the secant
// product and the divider. The input is ready only while the sequencer is
// idle. A finished result sits in the output register, so the next request can
// be accepted while the receiver stalls; that request then waits at its last
// step until the output register is free. Reset is synchronous: all
// configuration registers go to their defaults, both concentrations to the
// default initial value, and no result is pending.

module secant_concentration_search #(
    parameter int FACTOR_FRAC_BITS = 30,
    parameter int CONC_FRAC_BITS   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Slave stream. tdata: factor_mean[31:0], factor_prev_mean[63:32],
    // factor_std_dev[95:64]. tuser: first_step[0].
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [95:0]                 i_s_tdata,
    input  logic                        i_s_tuser,
    // Master stream. tdata: new_concentration[31:0], converged[32],
    // change_small[33], factor_in_band[34], slope_undefined[35],
    // saturated[36], uncertainty_high[37], zero fill[39:38].
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [39:0]                 o_m_tdata,
    // APB register port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scs_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam logic [31:0] TARGET_RESET = 32'(64'd1 << FACTOR_FRAC_BITS);
    localparam logic [31:0] EPS_RESET    = 32'(64'd1 << CONC_FRAC_BITS);
    localparam logic [32:0] STEP         = 33'(64'(scs_pkg::STEP_UNITS) << CONC_FRAC_BITS);
    localparam logic [31:0] INIT_RESET   = STEP[31:0];

    // Configuration registers.
    logic [31:0] r_target;
    logic [29:0] r_tol;
    logic [16:0] r_abund;
    logic [31:0] r_eps;
    logic [31:0] r_init;
    logic [15:0] r_conf;

    // Stored concentration pair.
    logic [31:0] r_conc;
    logic [31:0] r_prior;

    // Latched request.
    logic        r_first;
    logic [31:0] r_mean;
    logic [31:0] r_pmean;
    logic [31:0] r_sd;

    // Working registers.
    scs_pkg::t_state r_state, n_state;
    logic [35:0] r_width;
    logic [31:0] r_dk;
    logic        r_neg;
    logic        r_undef;
    logic        r_sat;
    logic [63:0] r_num;
    logic [31:0] r_rem;
    logic [5:0]  r_cnt;
    logic [48:0] r_cprod;
    logic [31:0] r_dt;

    logic        w_cfg_wr;
    logic        w_accept;
    logic        w_out_load;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    logic [31:0] w_change;
    logic        w_c_neg;
    logic [31:0] w_dt;
    logic        w_t_neg;
    logic [31:0] w_dk;
    logic        w_k_neg;
    logic        w_undef;
    logic [32:0] w_trial;
    logic        w_qbit;
    logic [31:0] n_conc;
    logic        n_sat;
    logic [32:0] w_first_sum;
    logic [64:0] w_sec_sum;
    logic        w_small;
    logic        w_band;
    logic        w_unc;
    logic [36:0] w_lhs1, w_rhs1, w_lhs2, w_rhs2;
    logic [31:0] w_dev;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_accept = i_s_tvalid && o_s_tready;

    // Register read-back.
    always_comb begin
        case (paddr[4:2])
            scs_pkg::REG_TARGET:     prdata = r_target;
            scs_pkg::REG_TOLERANCE:  prdata = {2'b0, r_tol};
            scs_pkg::REG_ABUNDANCE:  prdata = {15'b0, r_abund};
            scs_pkg::REG_EPSILON:    prdata = r_eps;
            scs_pkg::REG_INIT_CONC:  prdata = r_init;
            scs_pkg::REG_CONFIDENCE: prdata = {16'b0, r_conf};
            default:                 prdata = 32'b0;
        endcase
    end

    // Magnitudes and signs of the three differences.
    always_comb begin
        w_c_neg  = r_conc < r_prior;
        w_change = w_c_neg ? (r_prior - r_conc) : (r_conc - r_prior);
        w_t_neg  = r_target < r_mean;
        w_dt     = w_t_neg ? (r_mean - r_target) : (r_target - r_mean);
        w_k_neg  = r_mean < r_pmean;
        w_dk     = w_k_neg ? (r_pmean - r_mean) : (r_mean - r_pmean);
        w_undef  = !r_first && (r_mean == r_pmean);
    end

    // The shared multiplier.
    assign w_prod = w_mul_a * w_mul_b;

    // One restoring division step.
    assign w_trial = {r_rem, r_num[63]};
    assign w_qbit  = w_trial >= {1'b0, r_dk};

    // Concentration update.
    always_comb begin
        n_conc      = r_conc;
        n_sat       = 1'b0;
        w_first_sum = {1'b0, r_prior} + STEP;
        w_sec_sum   = {33'b0, r_conc} + {1'b0, r_num};
        if (r_first) begin
            if (r_mean > r_target) begin
                if (w_first_sum[32]) begin
                    n_conc = '1;
                    n_sat  = 1'b1;
                end else begin
                    n_conc = w_first_sum[31:0];
                end
            end else if (r_mean < r_target) begin
                n_conc = ({1'b0, r_prior} > STEP) ? (r_prior - STEP[31:0]) : 32'b0;
            end else begin
                n_conc = r_prior;
            end
        end else if (r_undef || r_num == 64'b0) begin
            n_conc = r_conc;
        end else if (r_neg) begin
            n_conc = (r_num >= {32'b0, r_conc}) ? 32'b0 : (r_conc - r_num[31:0]);
        end else if (w_sec_sum[64:32] != 33'b0) begin
            n_conc = '1;
            n_sat  = 1'b1;
        end else begin
            n_conc = w_sec_sum[31:0];
        end
    end

    // Result tests. The interval test t - tol <= m - w is rewritten as
    // t + w <= m + tol so that no term goes negative.
    always_comb begin
        w_small = r_cprod < {1'b0, r_eps, 16'b0};
        w_lhs1  = {5'b0, r_target} + {1'b0, r_width};
        w_rhs1  = {5'b0, r_mean} + {7'b0, r_tol};
        w_lhs2  = {5'b0, r_mean} + {1'b0, r_width};
        w_rhs2  = {5'b0, r_target} + {7'b0, r_tol};
        w_dev   = (r_mean >= r_target) ? (r_mean - r_target) : (r_target - r_mean);
        w_band  = ((w_lhs1 <= w_rhs1) && (w_lhs2 <= w_rhs2)) || (w_dev < {2'b0, r_tol});
        w_unc   = r_sd > {2'b0, r_tol};
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            scs_pkg::S_IDLE:   if (w_accept) n_state = scs_pkg::S_WMUL;
            scs_pkg::S_WMUL:   n_state = (r_first || w_undef) ? scs_pkg::S_UPDATE
                                                              : scs_pkg::S_SMUL;
            scs_pkg::S_SMUL:   n_state = scs_pkg::S_DIV;
            scs_pkg::S_DIV:    if (r_cnt == 6'(scs_pkg::DIV_STEPS - 1)) begin
                                   n_state = scs_pkg::S_UPDATE;
                               end
            scs_pkg::S_UPDATE: n_state = scs_pkg::S_CMUL;
            scs_pkg::S_CMUL:   n_state = scs_pkg::S_DONE;
            scs_pkg::S_DONE:   if (!o_m_tvalid || i_m_tready) n_state = scs_pkg::S_IDLE;
            default:           n_state = scs_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and multiplier operand selection.
    always_comb begin
        o_s_tready = 1'b0;
        w_out_load = 1'b0;
        w_mul_a    = 32'b0;
        w_mul_b    = 32'b0;
        case (r_state)
            scs_pkg::S_IDLE: o_s_tready = 1'b1;
            scs_pkg::S_WMUL: begin
                w_mul_a = r_sd;
                w_mul_b = {16'b0, r_conf};
            end
            scs_pkg::S_SMUL: begin
                w_mul_a = w_change;
                w_mul_b = r_dt;
            end
            scs_pkg::S_CMUL: begin
                w_mul_a = w_change;
                w_mul_b = {15'b0, r_abund};
            end
            scs_pkg::S_DONE: w_out_load = !o_m_tvalid || i_m_tready;
            default: ;
        endcase
    end

    // Control state, registers and the stored concentration pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= scs_pkg::S_IDLE;
            r_cnt      <= 6'b0;
            o_m_tvalid <= 1'b0;
            r_target   <= TARGET_RESET;
            r_tol      <= scs_pkg::TOL_RESET;
            r_abund    <= scs_pkg::ABUND_RESET;
            r_eps      <= EPS_RESET;
            r_init     <= INIT_RESET;
            r_conf     <= scs_pkg::CONF_RESET;
            r_conc     <= INIT_RESET;
            r_prior    <= INIT_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == scs_pkg::S_DIV) begin
                r_cnt <= r_cnt + 6'd1;
            end
            if (w_out_load) begin
                o_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
            if (r_state == scs_pkg::S_UPDATE && !r_undef) begin
                r_prior <= r_conc;
                r_conc  <= n_conc;
            end
            if (w_cfg_wr) begin
                case (paddr[4:2])
                    scs_pkg::REG_TARGET:     r_target <= pwdata;
                    scs_pkg::REG_TOLERANCE:  r_tol    <= pwdata[29:0];
                    scs_pkg::REG_ABUNDANCE:  r_abund  <= pwdata[16:0];
                    scs_pkg::REG_EPSILON:    r_eps    <= pwdata;
                    scs_pkg::REG_INIT_CONC: begin
                        r_init  <= pwdata;
                        r_conc  <= pwdata;
                        r_prior <= pwdata;
                    end
                    scs_pkg::REG_CONFIDENCE: r_conf   <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_first <= i_s_tuser;
            r_mean  <= i_s_tdata[31:0];
            r_pmean <= i_s_tdata[63:32];
            r_sd    <= i_s_tdata[95:64];
        end
        case (r_state)
            scs_pkg::S_WMUL: begin
                r_width <= w_prod[47:scs_pkg::CONF_FRAC];
                r_dt    <= w_dt;
                r_dk    <= w_dk;
                r_neg   <= (w_c_neg != w_t_neg) != w_k_neg;
                r_undef <= w_undef;
            end
            scs_pkg::S_SMUL: begin
                r_num <= w_prod;
                r_rem <= 32'b0;
            end
            scs_pkg::S_DIV: begin
                r_num <= {r_num[62:0], w_qbit};
                r_rem <= w_qbit ? 32'(w_trial - {1'b0, r_dk}) : w_trial[31:0];
            end
            scs_pkg::S_UPDATE: r_sat <= n_sat;
            scs_pkg::S_CMUL:   r_cprod <= w_prod[48:0];
            default: ;
        endcase
        if (w_out_load) begin
            o_m_tdata <= {2'b0, w_unc, r_sat, r_undef, w_band, w_small,
                          w_small && w_band, r_conc};
        end
    end

`ifndef SYNTH
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != scs_pkg::S_DIV) |-> (r_cnt == 6'b0))
        else $error("divider step count not at zero outside the division");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scs_pkg::S_DIV) |-> (r_rem < r_dk))
        else $error("division remainder reached the divisor");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[35] && o_m_tdata[36]))
        else $error("result flagged both undefined slope and saturation");

    a_converged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[32] == (o_m_tdata[33] && o_m_tdata[34])))
        else $error("converged flag disagrees with its two tests");

    a_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("input ready again right after a request was taken");
`endif

endmodule

>>> dv/scs_checker.sv
`timescale 1ns / 1ps
// Checker for the secant concentration search block: follows the register port
// and both streams, predicts every result and compares it field by field.
// Depends on scs_pkg for the register indexes and the fixed-point constants.

module scs_checker #(
    parameter int FACTOR_FRAC_BITS = 30,
    parameter int CONC_FRAC_BITS   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    // factor_mean[31:0], factor_prev_mean[63:32], factor_std_dev[95:64]
    input  logic [95:0]                 i_s_tdata,
    // first_step[0]
    input  logic                        i_s_tuser,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    // new_concentration[31:0], converged[32], change_small[33],
    // factor_in_band[34], slope_undefined[35], saturated[36],
    // uncertainty_high[37], zero fill[39:38]
    input  logic [39:0]                 i_m_tdata,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [scs_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [31:0]                 i_pwdata,
    input  logic                        i_pready,
    output int                          o_mismatches,
    output int                          o_pending,
    output int                          o_checked
);

    localparam logic [63:0] MAX_CONC = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] new_conc;
        logic        converged;
        logic        change_small;
        logic        in_band;
        logic        slope_undef;
        logic        saturated;
        logic        unc_high;
    } t_search_result;

    logic [31:0] cfg_target;
    logic [29:0] cfg_tol;
    logic [16:0] cfg_abund;
    logic [31:0] cfg_eps;
    logic [31:0] cfg_init;
    logic [15:0] cfg_conf;
    logic [31:0] conc_now;
    logic [31:0] conc_prior;

    t_search_result expected_results[$];
    int             mismatch_count = 0;
    int             results_checked = 0;
    int             pending_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;
    assign o_checked    = results_checked;

    function automatic t_search_result predict_search_step(
        input logic        first,
        input logic [31:0] mean,
        input logic [31:0] prev_mean,
        input logic [31:0] std_dev
    );
        logic [63:0]    step;
        logic [63:0]    next_conc;
        logic [63:0]    conc_gap;
        logic [63:0]    target_gap;
        logic [63:0]    factor_gap;
        logic [63:0]    shift;
        logic [63:0]    change;
        logic           conc_down;
        logic           target_down;
        logic           factor_down;
        longint         m;
        longint         t;
        longint         tol;
        longint         w;
        longint         dev;
        t_search_result r;

        step      = 64'(scs_pkg::STEP_UNITS) << CONC_FRAC_BITS;
        next_conc = 64'(conc_now);
        r         = '0;
        if (first) begin
            if (mean > cfg_target) begin
                next_conc = 64'(conc_prior) + step;
                if (next_conc > MAX_CONC) begin
                    next_conc   = MAX_CONC;
                    r.saturated = 1'b1;
                end
            end else if (mean < cfg_target) begin
                next_conc = (64'(conc_prior) > step) ? 64'(conc_prior) - step : 64'd0;
            end else begin
                next_conc = 64'(conc_prior);
            end
        end else if (mean == prev_mean) begin
            r.slope_undef = 1'b1;
        end else begin
            // Work on magnitudes and carry the signs apart, so the product stays exact.
            conc_down   = conc_now < conc_prior;
            conc_gap    = conc_down ? 64'(conc_prior - conc_now) : 64'(conc_now - conc_prior);
            target_down = cfg_target < mean;
            target_gap  = target_down ? 64'(mean - cfg_target) : 64'(cfg_target - mean);
            factor_down = mean < prev_mean;
            factor_gap  = factor_down ? 64'(prev_mean - mean) : 64'(mean - prev_mean);
            shift       = (conc_gap * target_gap) / factor_gap;
            if (shift == 64'd0) begin
                next_conc = 64'(conc_now);
            end else if (conc_down ^ target_down ^ factor_down) begin
                next_conc = (shift >= 64'(conc_now)) ? 64'd0 : 64'(conc_now) - shift;
            end else if (shift > MAX_CONC - 64'(conc_now)) begin
                next_conc   = MAX_CONC;
                r.saturated = 1'b1;
            end else begin
                next_conc = 64'(conc_now) + shift;
            end
        end

        if (!r.slope_undef) begin
            conc_prior = conc_now;
            conc_now   = next_conc[31:0];
        end

        change = (conc_now >= conc_prior) ? 64'(conc_now - conc_prior)
                                          : 64'(conc_prior - conc_now);
        r.change_small = (change * 64'(cfg_abund)) < (64'(cfg_eps) << scs_pkg::ABUND_FRAC);

        m   = longint'({32'd0, mean});
        t   = longint'({32'd0, cfg_target});
        tol = longint'({34'd0, cfg_tol});
        w   = longint'((64'(cfg_conf) * 64'(std_dev)) >> scs_pkg::CONF_FRAC);
        if ((t - tol <= m - w) && (m + w <= t + tol)) begin
            r.in_band = 1'b1;
        end else begin
            dev       = (m >= t) ? m - t : t - m;
            r.in_band = dev < tol;
        end

        r.new_conc  = conc_now;
        r.converged = r.change_small && r.in_band;
        r.unc_high  = std_dev > 32'(cfg_tol);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_search_result want;
        if (!i_rst_n) begin
            cfg_target = 32'd1 << FACTOR_FRAC_BITS;
            cfg_tol    = scs_pkg::TOL_RESET;
            cfg_abund  = scs_pkg::ABUND_RESET;
            cfg_eps    = 32'd1 << CONC_FRAC_BITS;
            cfg_init   = 32'(scs_pkg::STEP_UNITS) << CONC_FRAC_BITS;
            cfg_conf   = scs_pkg::CONF_RESET;
            conc_now   = cfg_init;
            conc_prior = cfg_init;
            expected_results.delete();
            pending_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    scs_pkg::REG_TARGET:     cfg_target = i_pwdata;
                    scs_pkg::REG_TOLERANCE:  cfg_tol    = i_pwdata[29:0];
                    scs_pkg::REG_ABUNDANCE:  cfg_abund  = i_pwdata[16:0];
                    scs_pkg::REG_EPSILON:    cfg_eps    = i_pwdata;
                    scs_pkg::REG_INIT_CONC: begin
                        cfg_init   = i_pwdata;
                        conc_now   = i_pwdata;
                        conc_prior = i_pwdata;
                    end
                    scs_pkg::REG_CONFIDENCE: cfg_conf   = i_pwdata[15:0];
                    default: ;
                endcase
            end

            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result %h arrived with no request outstanding", i_m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("new_concentration", want.new_conc, i_m_tdata[31:0]);
                    check_field("converged", 32'(want.converged), 32'(i_m_tdata[32]));
                    check_field("change_small", 32'(want.change_small), 32'(i_m_tdata[33]));
                    check_field("factor_in_band", 32'(want.in_band), 32'(i_m_tdata[34]));
                    check_field("slope_undefined", 32'(want.slope_undef), 32'(i_m_tdata[35]));
                    check_field("saturated", 32'(want.saturated), 32'(i_m_tdata[36]));
                    check_field("uncertainty_high", 32'(want.unc_high), 32'(i_m_tdata[37]));
                    results_checked++;
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(predict_search_step(
                    i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32], i_s_tdata[95:64]));
            end
            pending_count = expected_results.size();
        end
    end

endmodule

>>> dv/tb_secant_concentration_search.sv
`timescale 1ns / 1ps
// Testbench top for the secant concentration search block: clock, reset,
// register programming, request and result traffic, and the final verdict.
// Depends on scs_pkg, secant_concentration_search and scs_checker.

module tb_secant_concentration_search;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          PHASES       = 9;
    localparam int          PHASE_ITEMS  = 72;
    localparam logic [31:0] ONE_FACTOR   = 32'h4000_0000;  // 1.0 in Q2.30
    localparam logic [2:0]  REG_UNUSED   = 3'd6;

    logic                       i_clk;
    logic                       i_rst_n     = 1'b0;
    logic                       i_s_tvalid  = 1'b0;
    logic                       o_s_tready;
    logic [95:0]                i_s_tdata   = '0;
    logic                       i_s_tuser   = 1'b0;
    logic                       o_m_tvalid;
    logic                       i_m_tready  = 1'b0;
    logic [39:0]                o_m_tdata;
    logic                       psel        = 1'b0;
    logic                       penable     = 1'b0;
    logic                       pwrite      = 1'b0;
    logic [scs_pkg::ADDR_W-1:0] paddr       = '0;
    logic [31:0]                pwdata      = '0;
    logic [31:0]                prdata;
    logic                       pready;

    int          mismatches;
    int          pending;
    int          checked;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          requests_sent  = 0;
    int          settings_used  = 1;
    bit          hold_request   = 1'b0;
    logic [31:0] cur_target     = ONE_FACTOR;
    logic [29:0] cur_tol        = scs_pkg::TOL_RESET;

    secant_concentration_search u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    scs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random stalls, and on request one long hold-off.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // All tasks start and end in the time step of a rising edge.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (idx == scs_pkg::REG_TARGET) cur_target = value;
        if (idx == scs_pkg::REG_TOLERANCE) cur_tol = value[29:0];
    endtask

    task automatic send_request(input logic first, input logic [31:0] mean,
                                input logic [31:0] prev_mean, input logic [31:0] std_dev);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {std_dev, prev_mean, mean};
        i_s_tuser  <= first;
        do @(posedge i_clk); while (!o_s_tready);
        requests_sent++;
    endtask

    // Registers are only touched once every request has produced its result.
    task automatic wait_until_idle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] near_factor(input logic [31:0] centre);
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return centre;
            3, 4:    return centre + 32'($urandom_range(4096)) - 32'd2048;
            5:       return centre ^ (32'd1 << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic        first;
        logic [31:0] mean;
        logic [31:0] prev_mean;
        logic [31:0] std_dev;
        logic [31:0] value;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 30;
        recv_idle_pct = 75;

        // Reset settings: first pass in all three directions, then secant and extremes.
        send_request(1'b1, ONE_FACTOR + 32'd1000, 32'd0, 32'd0);
        send_request(1'b1, ONE_FACTOR - 32'd1000, 32'd7, 32'd400);
        send_request(1'b1, ONE_FACTOR, ONE_FACTOR, 32'd1000);
        send_request(1'b0, ONE_FACTOR - 32'd5000, ONE_FACTOR + 32'd20000, 32'd50000);
        send_request(1'b0, ONE_FACTOR + 32'd300, ONE_FACTOR + 32'd300, 32'd200);
        send_request(1'b0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_until_idle();

        // Near the top of the range both update kinds clip and flag saturation.
        apb_write(scs_pkg::REG_INIT_CONC, 32'hFFFF_0000);
        send_request(1'b1, ONE_FACTOR + 32'd1, 32'd0, 32'd0);
        send_request(1'b0, ONE_FACTOR - 32'd10, ONE_FACTOR - 32'd20, 32'd0);
        wait_until_idle();

        // From zero the concentration floors instead of wrapping.
        apb_write(scs_pkg::REG_INIT_CONC, 32'd0);
        send_request(1'b1, ONE_FACTOR - 32'd1, 32'd0, 32'd5);
        send_request(1'b1, ONE_FACTOR + 32'd1, 32'd0, 32'd5);
        send_request(1'b0, ONE_FACTOR + 32'd100, ONE_FACTOR + 32'd50, 32'd0);
        wait_until_idle();

        // Zero epsilon, zero tolerance, zero confidence; a write past the map is ignored.
        apb_write(scs_pkg::REG_ABUNDANCE, 32'd0);
        apb_write(scs_pkg::REG_EPSILON, 32'd0);
        apb_write(scs_pkg::REG_TOLERANCE, 32'd0);
        apb_write(scs_pkg::REG_CONFIDENCE, 32'd0);
        apb_write(scs_pkg::REG_TARGET, 32'hFFFF_FFFF);
        apb_write(REG_UNUSED, $urandom);
        send_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'd0);
        send_request(1'b0, 32'd1234, 32'd1234, 32'd99);
        wait_until_idle();

        // Widest settings, abundance above one.
        apb_write(scs_pkg::REG_ABUNDANCE, 32'h1_FFFF);
        apb_write(scs_pkg::REG_EPSILON, 32'hFFFF_FFFF);
        apb_write(scs_pkg::REG_TOLERANCE, 32'h3FFF_FFFF);
        apb_write(scs_pkg::REG_CONFIDENCE, 32'hFFFF);
        apb_write(scs_pkg::REG_TARGET, 32'd1);
        send_request(1'b1, 32'd0, 32'd5, 32'hFFFF_FFFF);
        send_request(1'b0, 32'h2000_0000, 32'h1000_0000, 32'h0000_1000);
        wait_until_idle();

        // Zero abundance with a nonzero epsilon always counts as a small change.
        apb_write(scs_pkg::REG_ABUNDANCE, 32'd0);
        apb_write(scs_pkg::REG_EPSILON, 32'd1);
        send_request(1'b0, 32'h8000_0000, 32'h7000_0000, 32'd12);
        send_request(1'b0, 32'h0000_0001, 32'h8000_0000, 32'd0);
        wait_until_idle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(5))
                0:       value = 32'd1;
                1:       value = 32'hFFFF_FFFF;
                2:       value = ONE_FACTOR;
                default: value = 32'h3000_0000 + $urandom_range(32'h2000_0000);
            endcase
            apb_write(scs_pkg::REG_TARGET, value);
            case ($urandom_range(5))
                0:       value = 32'd0;
                1:       value = 32'h3FFF_FFFF;
                2:       value = 32'(scs_pkg::TOL_RESET);
                default: value = $urandom_range(1, 32'h40_0000);
            endcase
            apb_write(scs_pkg::REG_TOLERANCE, value);
            case ($urandom_range(5))
                0:       value = 32'd0;
                1:       value = 32'd65536;
                2:       value = 32'h1_FFFF;
                default: value = $urandom_range(1, 65535);
            endcase
            apb_write(scs_pkg::REG_ABUNDANCE, value);
            case ($urandom_range(5))
                0:       value = 32'd0;
                1:       value = 32'hFFFF_FFFF;
                2:       value = 32'd1;
                default: value = $urandom_range(1, 32'h100_0000);
            endcase
            apb_write(scs_pkg::REG_EPSILON, value);
            case ($urandom_range(3))
                0:       value = 32'd0;
                1:       value = 32'hFFFF_FFFF;
                default: value = $urandom;
            endcase
            apb_write(scs_pkg::REG_INIT_CONC, value);
            case ($urandom_range(3))
                0:       value = 32'd0;
                1:       value = 32'hFFFF;
                default: value = $urandom_range(65535);
            endcase
            apb_write(scs_pkg::REG_CONFIDENCE, value);
            settings_used++;

            if (phase < 3) begin
                send_idle_pct = 30;
                recv_idle_pct = 75;
            end else if (phase < 6) begin
                send_idle_pct = 75;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Long result hold-off while requests keep coming, to back up the input.
                if (phase == 1 && k == 10) hold_request = 1'b1;
                first = ($urandom_range(99) < 15);
                mean  = near_factor(cur_target);
                case ($urandom_range(9))
                    0, 1:    prev_mean = mean;
                    2, 3, 4: prev_mean = near_factor(mean);
                    default: prev_mean = $urandom;
                endcase
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: std_dev = $urandom_range({cur_tol, 1'b0});
                    5, 6:          std_dev = $urandom;
                    7:             std_dev = 32'd0;
                    8:             std_dev = 32'hFFFF_FFFF;
                    default:       std_dev = $urandom >> $urandom_range(31);
                endcase
                send_request(first, mean, prev_mean, std_dev);
            end
            wait_until_idle();
        end

        repeat (100) @(posedge i_clk);
        $display("Sent %0d requests over %0d register settings; %0d results checked.",
                 requests_sent, settings_used, checked);
        $display("Traffic ran with sender and receiver stalls, one long hold-off, and none.");
        if (mismatches == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
